FILE: design/cda_pkg.sv
package cda_pkg;

    // Action codes carried by the action field of an input item.
    localparam logic [2:0] ACT_LOAD = 3'd0;
    localparam logic [2:0] ACT_SEC  = 3'd1;
    localparam logic [2:0] ACT_MIN  = 3'd2;
    localparam logic [2:0] ACT_HOUR = 3'd3;
    localparam logic [2:0] ACT_DAY  = 3'd4;

    // Unit moved by one step of the datapath.
    typedef enum logic [1:0] {
        UNIT_SEC  = 2'd0,
        UNIT_MIN  = 2'd1,
        UNIT_HOUR = 2'd2,
        UNIT_DAY  = 2'd3
    } unit_t;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  step;
        logic  up;
        unit_t unit;
    } dp_cmd_t;

    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  DAYS_31   = 5'd31;
    localparam logic [4:0]  DAYS_30   = 5'd30;
    localparam logic [4:0]  DAYS_29   = 5'd29;
    localparam logic [4:0]  DAYS_28   = 5'd28;

    // A 16-bit year is a multiple of 25 exactly when its product with the
    // inverse of 25 modulo 2^16 does not exceed (2^16 - 1) / 25.
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    // Days in a month; months outside 1 to 12 count as 30 days.
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic leap);
        logic [4:0] len;
        begin
            unique case (month)
                4'd2:                                   len = leap ? DAYS_29 : DAYS_28;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_31;
                default:                                len = DAYS_30;
            endcase
            return len;
        end
    endfunction

endpackage

FILE: design/cda_datapath.sv
module cda_datapath
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [5:0]  load_second,
    input  logic [5:0]  load_minute,
    input  logic [4:0]  load_hour,
    input  logic [4:0]  load_day,
    input  logic [3:0]  load_month,
    input  logic [15:0] load_year,
    output logic [5:0]  second_now,
    output logic [5:0]  minute_now,
    output logic [4:0]  hour_now,
    output logic [4:0]  day_now,
    output logic [3:0]  month_now,
    output logic [15:0] year_now
);

    logic [5:0]  second_reg, second_next;
    logic [5:0]  minute_reg, minute_next;
    logic [4:0]  hour_reg,   hour_next;
    logic [4:0]  day_reg,    day_next;
    logic [3:0]  month_reg,  month_next;
    logic [15:0] year_reg,   year_next;
    logic        leap_reg,   leap_next;
    logic [15:0] year_prod;
    logic        div25;

    // The leap flag is registered from the year, so it lags the year. A year
    // only moves at the turn of the year or on a load, and February is never
    // consulted before the flag catches up, so the lag is never seen.
    assign year_prod = 16'(year_reg * INV25);
    assign div25     = (year_prod <= DIV25_LIMIT);
    assign leap_next = (year_reg[1:0] == 2'd0) && (!div25 || (year_reg[3:0] == 4'd0));

    always_comb
    begin
        logic tick_min;
        logic tick_hour;
        logic tick_day;
        logic [3:0] prev_month;
        second_next = second_reg;
        minute_next = minute_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        tick_min    = 1'b0;
        tick_hour   = 1'b0;
        tick_day    = 1'b0;
        prev_month  = 4'(month_reg - 4'd1);
        if (cmd.load)
        begin
            second_next = load_second;
            minute_next = load_minute;
            hour_next   = load_hour;
            day_next    = load_day;
            month_next  = load_month;
            year_next   = load_year;
        end
        else if (cmd.step)
        begin
            if (cmd.unit == UNIT_SEC)
            begin
                if (cmd.up)
                begin
                    if (second_reg < SEC_MAX) second_next = 6'(second_reg + 6'd1);
                    else
                    begin
                        second_next = 6'd0;
                        tick_min    = 1'b1;
                    end
                end
                else if (second_reg != 6'd0) second_next = 6'(second_reg - 6'd1);
                else
                begin
                    second_next = SEC_MAX;
                    tick_min    = 1'b1;
                end
            end
            if ((cmd.unit == UNIT_MIN) || tick_min)
            begin
                if (cmd.up)
                begin
                    if (minute_reg < MIN_MAX) minute_next = 6'(minute_reg + 6'd1);
                    else
                    begin
                        minute_next = 6'd0;
                        tick_hour   = 1'b1;
                    end
                end
                else if (minute_reg != 6'd0) minute_next = 6'(minute_reg - 6'd1);
                else
                begin
                    minute_next = MIN_MAX;
                    tick_hour   = 1'b1;
                end
            end
            if ((cmd.unit == UNIT_HOUR) || tick_hour)
            begin
                if (cmd.up)
                begin
                    if (hour_reg < HOUR_MAX) hour_next = 5'(hour_reg + 5'd1);
                    else
                    begin
                        hour_next = 5'd0;
                        tick_day  = 1'b1;
                    end
                end
                else if (hour_reg != 5'd0) hour_next = 5'(hour_reg - 5'd1);
                else
                begin
                    hour_next = HOUR_MAX;
                    tick_day  = 1'b1;
                end
            end
            if ((cmd.unit == UNIT_DAY) || tick_day)
            begin
                if (cmd.up)
                begin
                    if (day_reg < month_length(month_reg, leap_reg))
                        day_next = 5'(day_reg + 5'd1);
                    else if (month_reg < MONTH_DEC)
                    begin
                        month_next = 4'(month_reg + 4'd1);
                        day_next   = 5'd1;
                    end
                    else
                    begin
                        month_next = 4'd1;
                        day_next   = 5'd1;
                        year_next  = 16'(year_reg + 16'd1);
                    end
                end
                else if (day_reg > 5'd1) day_next = 5'(day_reg - 5'd1);
                else if (month_reg > 4'd1)
                begin
                    month_next = prev_month;
                    day_next   = month_length(prev_month, leap_reg);
                end
                else
                begin
                    month_next = MONTH_DEC;
                    day_next   = DAYS_31;
                    year_next  = 16'(year_reg - 16'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 6'd0;
            minute_reg <= 6'd0;
            hour_reg   <= 5'd0;
            day_reg    <= 5'd1;
            month_reg  <= 4'd1;
            year_reg   <= 16'd1;
            leap_reg   <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            leap_reg   <= leap_next;
        end
    end

    assign second_now = second_reg;
    assign minute_now = minute_reg;
    assign hour_now   = hour_reg;
    assign day_now    = day_reg;
    assign month_now  = month_reg;
    assign year_now   = year_reg;

    // The year may only move on a load or a step, and by one per step.
    a_year_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.load && !cmd.step) |=> $stable(year_reg))
        else $error("year changed with no load or step");

    a_load_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (year_reg == $past(load_year)) && (day_reg == $past(load_day)))
        else $error("load did not take the given date");

endmodule

FILE: design/cda_ctrl.sv
module cda_ctrl
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  action,
    input  logic [15:0] amount,
    output logic        busy,
    output logic        done,
    output dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] count_reg, count_next;
    logic        up_reg,    up_next;
    unit_t       unit_reg,  unit_next;
    logic        accept;
    logic [15:0] magnitude;
    logic        is_add;
    unit_t       unit_sel;

    assign accept    = start && (state_reg == ST_IDLE);
    assign magnitude = amount[15] ? 16'(~amount + 16'd1) : amount;

    always_comb
    begin
        is_add   = 1'b1;
        unit_sel = UNIT_SEC;
        unique case (action)
            ACT_SEC:  unit_sel = UNIT_SEC;
            ACT_MIN:  unit_sel = UNIT_MIN;
            ACT_HOUR: unit_sel = UNIT_HOUR;
            ACT_DAY:  unit_sel = UNIT_DAY;
            default:  is_add   = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        up_next    = up_reg;
        unit_next  = unit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    count_next = magnitude;
                    up_next    = ~amount[15];
                    unit_next  = unit_sel;
                    state_next = (is_add && (magnitude != 16'd0)) ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                count_next = 16'(count_reg - 16'd1);
                if (count_reg == 16'd1) state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 16'd0;
            up_reg    <= 1'b1;
            unit_reg  <= UNIT_SEC;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            up_reg    <= up_next;
            unit_reg  <= unit_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_DONE);
    assign cmd.load = accept && (action == ACT_LOAD);
    assign cmd.step = (state_reg == ST_RUN);
    assign cmd.up   = up_reg;
    assign cmd.unit = unit_reg;

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (count_reg != 16'd0))
        else $error("stepping with no steps left");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (count_reg == 16'd1)) |=> done)
        else $error("no result after the last step");

    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> done)
        else $error("load not answered in the next cycle");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe not followed by idle");

endmodule

FILE: design/calendar_datetime_adder_unit.sv
// Channel   Handshake           Ports
// -------   -----------------   ----------------------------------------------------
// command   start && !busy      action, amount, load_second .. load_year
// result    done (one cycle)    second_now, minute_now, hour_now, day_now, month_now,
//                               year_now
//
// A load, an unused action or a zero amount is answered in the cycle after it is taken.
// An add of n units steps the date once per clock in the single stepping datapath, n
// steps in all, up to 32768 for -32768, and then gives its result. After the result the
// block returns to idle before it takes the next item, so no new item is taken mid-add.
// Reset (rst_n low, asynchronous) gives 00:00:00 on 1 January of year 1 and clears busy.
// Results cannot be held off: done is high for exactly one cycle and the receiver takes it.
module calendar_datetime_adder_unit
    import cda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [15:0] amount,
    input  logic [5:0]  load_second,
    input  logic [5:0]  load_minute,
    input  logic [4:0]  load_hour,
    input  logic [4:0]  load_day,
    input  logic [3:0]  load_month,
    input  logic [15:0] load_year,
    output logic        done,
    output logic [5:0]  second_now,
    output logic [5:0]  minute_now,
    output logic [4:0]  hour_now,
    output logic [4:0]  day_now,
    output logic [3:0]  month_now,
    output logic [15:0] year_now
);

    // The controller decodes each item and counts down the steps; the datapath
    // holds the date and time and moves it by one unit when told to.
    dp_cmd_t cmd;

    cda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .amount (amount),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    // The result ports show the date registers directly. They are only
    // meaningful while done is high, when the registers are at rest.
    cda_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .load_second (load_second),
        .load_minute (load_minute),
        .load_hour   (load_hour),
        .load_day    (load_day),
        .load_month  (load_month),
        .load_year   (load_year),
        .second_now  (second_now),
        .minute_now  (minute_now),
        .hour_now    (hour_now),
        .day_now     (day_now),
        .month_now   (month_now),
        .year_now    (year_now)
    );

endmodule

FILE: tb/sv/calendar_tracker_pkg.sv
`timescale 1ns / 100ps

package calendar_tracker_pkg;

    import cda_pkg::*;

    // One date and time of day, at the widths of the block's ports.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

    // Tracks the calendar as the block should hold it and keeps the stamps still owed.
    class calendar_tracker;

        stamp_t      clock_now;
        stamp_t      expected_stamps[$];
        int unsigned mismatch_count;

        function new();
            clock_now = '{year: 16'd1, month: 4'd1, day: 5'd1, default: '0};
            mismatch_count = 0;
        endfunction

        function bit is_leap(logic [15:0] y);
            if (y % 16'd400 == 16'd0)
                return 1'b1;
            if (y % 16'd100 == 16'd0)
                return 1'b0;
            return y[1:0] == 2'b00;
        endfunction

        // Months outside January to December count as 30 days.
        function logic [4:0] month_days(logic [3:0] m, logic [15:0] y);
            case (m)
                4'd2:                                       return is_leap(y) ? 5'd29 : 5'd28;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
                default:                                    return 5'd30;
            endcase
        endfunction

        function void day_step(bit up);
            if (up)
            begin
                if (clock_now.day < month_days(clock_now.month, clock_now.year))
                    clock_now.day = clock_now.day + 5'd1;
                else if (clock_now.month < 4'd12)
                begin
                    clock_now.month = clock_now.month + 4'd1;
                    clock_now.day = 5'd1;
                end
                else
                begin
                    clock_now.month = 4'd1;
                    clock_now.day = 5'd1;
                    clock_now.year = clock_now.year + 16'd1;
                end
            end
            else
            begin
                if (clock_now.day > 5'd1)
                    clock_now.day = clock_now.day - 5'd1;
                else if (clock_now.month > 4'd1)
                begin
                    clock_now.month = clock_now.month - 4'd1;
                    clock_now.day = month_days(clock_now.month, clock_now.year);
                end
                else
                begin
                    clock_now.month = 4'd12;
                    clock_now.day = 5'd31;
                    clock_now.year = clock_now.year - 16'd1;
                end
            end
        endfunction

        function void hour_step(bit up);
            if (up)
            begin
                if (clock_now.hour < HOUR_MAX)
                    clock_now.hour = clock_now.hour + 5'd1;
                else
                begin
                    clock_now.hour = 5'd0;
                    day_step(1'b1);
                end
            end
            else if (clock_now.hour > 5'd0)
                clock_now.hour = clock_now.hour - 5'd1;
            else
            begin
                clock_now.hour = HOUR_MAX;
                day_step(1'b0);
            end
        endfunction

        function void minute_step(bit up);
            if (up)
            begin
                if (clock_now.minute < MIN_MAX)
                    clock_now.minute = clock_now.minute + 6'd1;
                else
                begin
                    clock_now.minute = 6'd0;
                    hour_step(1'b1);
                end
            end
            else if (clock_now.minute > 6'd0)
                clock_now.minute = clock_now.minute - 6'd1;
            else
            begin
                clock_now.minute = MIN_MAX;
                hour_step(1'b0);
            end
        endfunction

        function void second_step(bit up);
            if (up)
            begin
                if (clock_now.second < SEC_MAX)
                    clock_now.second = clock_now.second + 6'd1;
                else
                begin
                    clock_now.second = 6'd0;
                    minute_step(1'b1);
                end
            end
            else if (clock_now.second > 6'd0)
                clock_now.second = clock_now.second - 6'd1;
            else
            begin
                clock_now.second = SEC_MAX;
                minute_step(1'b0);
            end
        endfunction

        // Applies one accepted item and queues the stamp that it must produce.
        function void note_command(logic [2:0] act, logic [15:0] amt, stamp_t loaded);
            bit          up;
            logic [16:0] steps;
            up = ~amt[15];
            steps = up ? {1'b0, amt} : 17'h10000 - {1'b0, amt};
            case (act)
                ACT_LOAD: clock_now = loaded;
                ACT_SEC, ACT_MIN, ACT_HOUR, ACT_DAY:
                    for (int unsigned i = 0; i < steps; i++)
                    begin
                        case (act)
                            ACT_SEC:  second_step(up);
                            ACT_MIN:  minute_step(up);
                            ACT_HOUR: hour_step(up);
                            default:  day_step(up);
                        endcase
                    end
                default: ;
            endcase
            expected_stamps.push_back(clock_now);
        endfunction

        task flag_mismatch(string what);
            $display("%0t mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_stamp(stamp_t got);
            stamp_t want;
            if (expected_stamps.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with no item pending",
                    got.year, got.month, got.day, got.hour, got.minute, got.second));
                return;
            end
            want = expected_stamps.pop_front();
            compare_field("second_now", got.second, want.second);
            compare_field("minute_now", got.minute, want.minute);
            compare_field("hour_now", got.hour, want.hour);
            compare_field("day_now", got.day, want.day);
            compare_field("month_now", got.month, want.month);
            compare_field("year_now", got.year, want.year);
        endtask

        function int unsigned pending();
            return expected_stamps.size();
        endfunction

    endclass

endpackage

FILE: tb/sv/calendar_datetime_adder_unit_test.sv
`timescale 1ns / 100ps

module calendar_datetime_adder_unit_test;

    import cda_pkg::*;
    import calendar_tracker_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [15:0] amount;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
    logic        done;
    logic [5:0]  second_now;
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [15:0] year_now;

    // The tracker predicts every stamp; idle_on lets the sender leave gaps between items.
    calendar_tracker tracker = new();
    bit              idle_on;

    calendar_datetime_adder_unit dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Builds the load fields of an item from a date and a time of day.
    function automatic stamp_t stamp(int unsigned y, int unsigned mo, int unsigned d,
                                     int unsigned h, int unsigned mi, int unsigned s);
        stamp_t st;
        st.year = 16'(y);
        st.month = 4'(mo);
        st.day = 5'(d);
        st.hour = 5'(h);
        st.minute = 6'(mi);
        st.second = 6'(s);
        return st;
    endfunction

    // Presents one item, starting and ending at a falling edge. Start is left high when the
    // task returns, so that the next item can follow without a gap; it is only lowered when
    // a gap is wanted, and never lowered and raised again in the same time step.
    task send_command(logic [2:0] act, logic [15:0] amt, stamp_t ld);
        int gap;
        if (idle_on && $urandom_range(99) < 10)
        begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        amount <= amt;
        load_second <= ld.second;
        load_minute <= ld.minute;
        load_hour <= ld.hour;
        load_day <= ld.day;
        load_month <= ld.month;
        load_year <= ld.year;
        // Busy is read just after the rising edge, before the block's own updates land, so
        // it shows the value that the edge itself saw.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(act, amt, ld);
        @(negedge clk);
    endtask

    // Results cannot be held off, so every cycle with done high carries a stamp to check.
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_stamp(stamp(year_now, month_now, day_now,
                                      hour_now, minute_now, second_now));
    end

    initial
    begin
        stamp_t      ld;
        logic [2:0]  act;
        logic [15:0] amt;
        logic [4:0]  days;
        int          pick;

        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_LOAD;
        amount = '0;
        load_second = '0;
        load_minute = '0;
        load_hour = '0;
        load_day = '0;
        load_month = '0;
        load_year = '0;
        idle_on = 1'b1;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // An unused action reports the state left by reset and ignores its amount.
        send_command(3'd5, 16'h7FFF, stamp(0, 0, 0, 0, 0, 0));
        // The last second of year 65535 rolls forward into year 0 and back again.
        send_command(ACT_LOAD, 16'd0, stamp(65535, 12, 31, 23, 59, 59));
        send_command(ACT_SEC, 16'd1, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_SEC, 16'hFFFF, stamp(0, 0, 0, 0, 0, 0));
        // A zero amount leaves the state untouched.
        send_command(ACT_DAY, 16'd0, stamp(0, 0, 0, 0, 0, 0));
        // Leap years under the 400, 100 and 4 rules.
        send_command(ACT_LOAD, 16'd0, stamp(2000, 2, 28, 6, 30, 15));
        send_command(ACT_DAY, 16'd2, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_LOAD, 16'd0, stamp(1900, 2, 28, 0, 0, 0));
        send_command(ACT_DAY, 16'd1, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_LOAD, 16'd0, stamp(2100, 3, 1, 0, 0, 0));
        send_command(ACT_DAY, 16'hFFFF, stamp(0, 0, 0, 0, 0, 0));
        // Stepping back from the first of January lands on the last day of the year before.
        send_command(ACT_LOAD, 16'd0, stamp(2023, 1, 1, 0, 0, 0));
        send_command(ACT_MIN, 16'hFFFF, stamp(0, 0, 0, 0, 0, 0));
        // The largest amounts in both directions.
        send_command(ACT_MIN, 16'h7FFF, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_DAY, 16'h8000, stamp(0, 0, 0, 0, 0, 0));
        // Loaded values out of range are kept and stepped as the block defines.
        send_command(ACT_LOAD, 16'd0, stamp(65535, 15, 31, 31, 63, 63));
        send_command(ACT_SEC, 16'd1, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_MIN, 16'hFFFF, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_LOAD, 16'd0, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_DAY, 16'hFFFF, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_LOAD, 16'd0, stamp(2024, 13, 31, 23, 0, 0));
        send_command(ACT_HOUR, 16'd1, stamp(0, 0, 0, 0, 0, 0));
        send_command(ACT_LOAD, 16'd0, stamp(2024, 14, 0, 0, 0, 0));
        send_command(ACT_DAY, 16'hFFFF, stamp(0, 0, 0, 0, 0, 0));
        send_command(3'd7, 16'h8000, stamp(65535, 15, 31, 31, 63, 63));

        // Random items. Loads mostly place the calendar just short of a boundary so that the
        // adds that follow ripple through months and years; a few loads are raw bit patterns.
        // Amounts are mostly small, with a handful at full range since those take long.
        for (int k = 0; k < 100; k++)
        begin
            idle_on = !(k >= 40 && k < 70);
            ld = stamp(16'($urandom), 4'($urandom), 5'($urandom),
                       5'($urandom), 6'($urandom), 6'($urandom));
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                act = ACT_LOAD;
                if ($urandom_range(3) != 0)
                begin
                    case ($urandom_range(5))
                        0:       ld.year = 16'd0;
                        1:       ld.year = 16'hFFFF;
                        2:       ld.year = 16'd1900;
                        3:       ld.year = 16'd2000;
                        4:       ld.year = 16'd2100;
                        default: ld.year = 16'($urandom);
                    endcase
                    ld.month = 4'($urandom_range(12, 1));
                    days = tracker.month_days(ld.month, ld.year);
                    ld.day = $urandom_range(1) ? 5'($urandom_range(days, days - 5'd1))
                                               : 5'($urandom_range(days, 1));
                    ld.hour = $urandom_range(1) ? HOUR_MAX : 5'($urandom_range(23));
                    ld.minute = $urandom_range(1) ? MIN_MAX : 6'($urandom_range(59));
                    ld.second = $urandom_range(1) ? SEC_MAX : 6'($urandom_range(59));
                end
            end
            else if (pick < 25)
                act = 3'($urandom_range(7, 5));
            else
                act = 3'($urandom_range(ACT_DAY, ACT_SEC));

            pick = $urandom_range(99);
            if (pick < 3)
                amt = 16'($urandom);
            else if (pick < 15)
                amt = 16'($urandom_range(4000)) - 16'd2000;
            else
                amt = 16'($urandom_range(120)) - 16'd60;

            send_command(act, amt, ld);
        end

        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        // A last idle stretch in which any stray result would still be caught.
        repeat (4) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("calendar_datetime_adder_unit_test: done, clean");
        else
            $display("calendar_datetime_adder_unit_test: done, errors");
        $finish;
    end

    // Even with every item at the largest amount the run ends well within this bound.
    initial
    begin
        #150_000_000;
        $display("calendar_datetime_adder_unit_test: done, errors");
        $finish;
    end

endmodule
